@@ design/qps_pkg.sv @@
// ----------------------------------------------------------------------------
// qps_pkg
// Shared types and constants for the quadrature position and speed core.
// ----------------------------------------------------------------------------
package qps_pkg;

  localparam int CNT_W      = 16;
  localparam int TICK_W     = 32;
  localparam int POS_W      = 32;
  localparam int SPEED_W    = 31;
  localparam int CPR_W      = 16;
  localparam int WIN_W      = 16;
  localparam int SCALE_W    = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam int DIVIDEND_W = POS_W + SCALE_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_ITERS  = DIVIDEND_W / DIV_STEPS;
  localparam int ITER_W     = $clog2(DIV_ITERS);

  localparam logic [CPR_W-1:0]   CPR_RST     = 16'd7680;
  localparam logic [WIN_W-1:0]   WIN_RST     = 16'd500;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 20'd12000;
  localparam logic [SCALE_W-1:0] DEG_PER_REV = 20'd360;
  localparam logic [SPEED_W-1:0] SPEED_MAX   = 31'h7FFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_CPR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

  typedef enum logic [1:0] {
    KIND_UPDATE    = 2'd0,
    KIND_FULL_RST  = 2'd1,
    KIND_SPEED_RST = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ANGLE,
    S_SPEED,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic [CPR_W-1:0]   cpr;
    logic [WIN_W-1:0]   win;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [POS_W-1:0] a;
    logic [SCALE_W-1:0]      b;
    logic [CPR_W-1:0]        divisor;
  } md_req_t;

  typedef struct packed {
    logic                  done;
    logic                  neg;
    logic [DIVIDEND_W-1:0] quot;
  } md_rsp_t;

endpackage

@@ design/qps_if.sv @@
// ----------------------------------------------------------------------------
// qps channel interfaces
// Valid/ready channels for encoder samples and position/speed results.
// ----------------------------------------------------------------------------
interface qps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] counter_value;
  logic [31:0] time_tick;

  modport source (output valid, kind, counter_value, time_tick, input ready);
  modport sink   (input valid, kind, counter_value, time_tick, output ready);
endinterface

interface qps_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] step_delta;
  logic signed [31:0] position_count;
  logic signed [31:0] angle_deg;
  logic [30:0]        speed_rpm;

  modport source (output valid, step_delta, position_count, angle_deg, speed_rpm,
                  input ready);
  modport sink   (input valid, step_delta, position_count, angle_deg, speed_rpm,
                  output ready);
endinterface

@@ design/quadrature_position_speed_core.sv @@
// ----------------------------------------------------------------------------
// quadrature_position_speed_core
// Encoder position, angle and windowed rpm from raw counter samples.
//
//   channel  dir  payload                                           role
//   in_if    in   kind, counter_value, time_tick                    sample
//   out_if   out  step_delta, position_count, angle_deg, speed_rpm  result
//   cfg_*    in   cfg_index, cfg_data under cfg_we                  registers
//
// an update is accepted, runs the angle divide and, when the speed window
// closes, the speed divide, then waits to load the output register: each
// divide by counts_per_rev is a multiply step, passes of the shared 4-bit
// divider and a done step. resets and unused kinds go straight to the load.
// rst_n is synchronous; one item in flight, in_if.ready only when idle.
// a stalled result holds in the output register; the next item is taken
// while it waits, and its result waits until the transfer completes.
// ----------------------------------------------------------------------------
module quadrature_position_speed_core (
  input  logic                           clk,
  input  logic                           rst_n,
  qps_in_if.sink                         in_if,
  qps_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [qps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qps_pkg::*;

  cfg_t    cfg;
  md_req_t req;
  md_rsp_t rsp;

  seq_state_t              state_r, state_nxt;
  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic signed [POS_W-1:0] angle_r, angle_nxt;
  logic signed [POS_W-1:0] sum_r, sum_nxt;
  logic [TICK_W-1:0]       start_r, start_nxt;
  logic [CNT_W-1:0]        prev_r, prev_nxt;
  logic                    skip_r, skip_nxt;
  logic [SPEED_W-1:0]      speed_r, speed_nxt;
  logic                    win_r, win_nxt;
  logic signed [CNT_W-1:0] delta_r, delta_nxt;
  logic [TICK_W-1:0]       tick_r, tick_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [CNT_W-1:0] out_delta_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic signed [POS_W-1:0] out_angle_r;
  logic [SPEED_W-1:0]      out_speed_r;
  logic                    out_load;

  logic                    accept;
  logic [CNT_W-1:0]        delta;
  logic signed [POS_W-1:0] dsext;
  logic signed [POS_W-1:0] pos_sum;
  logic signed [POS_W-1:0] win_sum;
  logic [TICK_W-1:0]       elapsed;
  logic                    close;
  logic [SPEED_W-1:0]      speed_sat;

  qps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  qps_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  assign delta   = in_if.counter_value - prev_r;
  assign dsext   = {{(POS_W-CNT_W){delta[CNT_W-1]}}, delta};
  assign pos_sum = pos_r + dsext;
  assign win_sum = sum_r + dsext;
  assign elapsed = in_if.time_tick - start_r;
  assign close   = elapsed >= TICK_W'(cfg.win);

  assign speed_sat = (|rsp.quot[DIVIDEND_W-1:SPEED_W]) ? SPEED_MAX
                                                       : rsp.quot[SPEED_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    angle_nxt     = angle_r;
    sum_nxt       = sum_r;
    start_nxt     = start_r;
    prev_nxt      = prev_r;
    skip_nxt      = skip_r;
    speed_nxt     = speed_r;
    win_nxt       = win_r;
    delta_nxt     = delta_r;
    tick_nxt      = tick_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_load      = 1'b0;
    req.start     = 1'b0;
    req.a         = pos_sum;
    req.b         = DEG_PER_REV;
    req.divisor   = (cfg.cpr == '0) ? CPR_W'(1) : cfg.cpr;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tick_nxt  = in_if.time_tick;
          delta_nxt = '0;
          state_nxt = S_DONE;
          case (kind_t'(in_if.kind))
            KIND_UPDATE: begin
              delta_nxt = delta;
              prev_nxt  = in_if.counter_value;
              pos_nxt   = pos_sum;
              sum_nxt   = win_sum;
              win_nxt   = close;
              req.start = 1'b1;
              state_nxt = S_ANGLE;
            end
            KIND_FULL_RST: begin
              pos_nxt   = '0;
              angle_nxt = '0;
              speed_nxt = '0;
              prev_nxt  = '0;
              start_nxt = in_if.time_tick;
            end
            KIND_SPEED_RST: begin
              sum_nxt   = '0;
              speed_nxt = '0;
              prev_nxt  = in_if.counter_value;
              start_nxt = in_if.time_tick;
              skip_nxt  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ANGLE: begin
        req.a = sum_r;
        req.b = cfg.scale;
        if (rsp.done) begin
          angle_nxt = rsp.neg ? -rsp.quot[POS_W-1:0] : rsp.quot[POS_W-1:0];
          if (win_r) begin
            req.start = 1'b1;
            state_nxt = S_SPEED;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SPEED: begin
        if (rsp.done) begin
          if (skip_r) skip_nxt = 1'b0;
          else        speed_nxt = speed_sat;
          sum_nxt   = '0;
          start_nxt = tick_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      angle_r     <= '0;
      sum_r       <= '0;
      start_r     <= '0;
      prev_r      <= '0;
      skip_r      <= 1'b0;
      speed_r     <= '0;
      win_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      angle_r     <= angle_nxt;
      sum_r       <= sum_nxt;
      start_r     <= start_nxt;
      prev_r      <= prev_nxt;
      skip_r      <= skip_nxt;
      speed_r     <= speed_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r <= delta_nxt;
    tick_r  <= tick_nxt;
    if (out_load) begin
      out_delta_r <= delta_r;
      out_pos_r   <= pos_r;
      out_angle_r <= angle_r;
      out_speed_r <= speed_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.step_delta     = out_delta_r;
  assign out_if.position_count = out_pos_r;
  assign out_if.angle_deg      = out_angle_r;
  assign out_if.speed_rpm      = out_speed_r;

endmodule

@@ design/qps_cfg.sv @@
// ----------------------------------------------------------------------------
// qps_cfg
// Configuration register file: counts per rev, window length, speed scale.
// ----------------------------------------------------------------------------
module qps_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [qps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output qps_pkg::cfg_t                    cfg_o
);
  import qps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpr   <= CPR_RST;
      cfg_r.win   <= WIN_RST;
      cfg_r.scale <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CPR:   cfg_r.cpr   <= cfg_data[CPR_W-1:0];
        CFG_WIN:   cfg_r.win   <= cfg_data[WIN_W-1:0];
        CFG_SCALE: cfg_r.scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ design/qps_muldiv.sv @@
// ----------------------------------------------------------------------------
// qps_muldiv
// Shared magnitude multiplier followed by a radix-16 restoring divider.
// ----------------------------------------------------------------------------
module qps_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  qps_pkg::md_req_t req,
  output qps_pkg::md_rsp_t rsp
);
  import qps_pkg::*;

  md_state_t               state_r, state_nxt;
  logic [POS_W-1:0]        a_r;
  logic [SCALE_W-1:0]      b_r;
  logic [CPR_W-1:0]        div_r;
  logic                    neg_r;
  logic [DIVIDEND_W-1:0]   dvd_r, dvd_nxt;
  logic [CPR_W-1:0]        rem_r, rem_nxt;
  logic [ITER_W-1:0]       cnt_r;
  logic                    done_r, done_nxt;
  logic [POS_W-1:0]        abs_a;
  logic [DIVIDEND_W-1:0]   prod;
  logic [DIVIDEND_W-1:0]   step_dvd;
  logic [CPR_W-1:0]        step_rem;

  assign abs_a = a_r[POS_W-1] ? (~a_r + 1'b1) : a_r;
  assign prod  = DIVIDEND_W'(abs_a) * DIVIDEND_W'(b_r);

  always_comb begin
    logic [CPR_W:0]        trial;
    logic [CPR_W-1:0]      rem_v;
    logic [DIVIDEND_W-1:0] dvd_v;
    rem_v = rem_r;
    dvd_v = dvd_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_v, dvd_v[DIVIDEND_W-1]};
      dvd_v = {dvd_v[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        trial    = trial - {1'b0, div_r};
        dvd_v[0] = 1'b1;
      end
      rem_v = trial[CPR_W-1:0];
    end
    step_dvd = dvd_v;
    step_rem = rem_v;
  end

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    case (state_r)
      MD_IDLE: begin
        if (req.start) state_nxt = MD_MUL;
      end
      MD_MUL: begin
        dvd_nxt   = prod;
        rem_nxt   = '0;
        state_nxt = MD_DIV;
      end
      MD_DIV: begin
        dvd_nxt = step_dvd;
        rem_nxt = step_rem;
        if (cnt_r == ITER_W'(DIV_ITERS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      if (state_r == MD_DIV) cnt_r <= cnt_r + 1'b1;
      else                   cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (state_r == MD_IDLE && req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      div_r <= req.divisor;
      neg_r <= req.a[POS_W-1];
    end
  end

  assign rsp.done = done_r;
  assign rsp.neg  = neg_r;
  assign rsp.quot = dvd_r;

endmodule

@@ dv/qps_result_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qps_result_check
// Watches the sample, result and register ports of the quadrature position
// and speed core, tracks encoder position, angle and windowed rpm for every
// sample transfer, and compares each result transfer with the oldest
// predicted reading.
// ----------------------------------------------------------------------------
module qps_result_check (
  input  logic                           clk,
  input  logic                           rst_n,
  qps_in_if                              in_mon,
  qps_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [qps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qps_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  import qps_pkg::*;

  typedef struct packed {
    logic signed [15:0] step_delta;
    logic signed [31:0] position_count;
    logic signed [31:0] angle_deg;
    logic [30:0]        speed_rpm;
  } reading_t;

  logic [CPR_W-1:0]   cpr_q;
  logic [WIN_W-1:0]   win_q;
  logic [SCALE_W-1:0] scale_q;

  logic [31:0] pos_q;
  logic [31:0] angle_q;
  logic [31:0] wsum_q;
  logic [31:0] wstart_q;
  logic [15:0] prev_cnt_q;
  logic        skip_q;
  logic [30:0] rpm_q;

  reading_t pending_readings[$];
  int       bad_count;

  function automatic reading_t advance_encoder(kind_t k, logic [15:0] cnt,
                                               logic [31:0] tick);
    reading_t    r;
    logic [15:0] d;
    logic [31:0] dx;
    logic [31:0] elapsed;
    longint      div;
    longint      q;
    longint      s;
    d   = '0;
    div = (cpr_q == '0) ? 64'sd1 : longint'(cpr_q);
    case (k)
      KIND_UPDATE: begin
        d          = cnt - prev_cnt_q;
        prev_cnt_q = cnt;
        dx         = {{16{d[15]}}, d};
        pos_q      = pos_q + dx;
        q          = longint'($signed(pos_q)) * 360 / div;
        angle_q    = q[31:0];
        wsum_q     = wsum_q + dx;
        elapsed    = tick - wstart_q;
        if (elapsed >= 32'(win_q)) begin
          s = longint'($signed(wsum_q)) * longint'(scale_q) / div;
          if (s < 0) s = -s;
          if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
          if (skip_q) skip_q = 1'b0;
          else rpm_q = s[30:0];
          wsum_q   = '0;
          wstart_q = tick;
        end
      end
      KIND_FULL_RST: begin
        pos_q      = '0;
        angle_q    = '0;
        rpm_q      = '0;
        prev_cnt_q = '0;
        wstart_q   = tick;
      end
      KIND_SPEED_RST: begin
        wsum_q     = '0;
        rpm_q      = '0;
        prev_cnt_q = cnt;
        wstart_q   = tick;
        skip_q     = 1'b1;
      end
      default: ;
    endcase
    r.step_delta     = d;
    r.position_count = pos_q;
    r.angle_deg      = angle_q;
    r.speed_rpm      = rpm_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    reading_t got;
    if (!rst_n) begin
      cpr_q      = CPR_RST;
      win_q      = WIN_RST;
      scale_q    = SCALE_RST;
      pos_q      = '0;
      angle_q    = '0;
      wsum_q     = '0;
      wstart_q   = '0;
      prev_cnt_q = '0;
      skip_q     = 1'b0;
      rpm_q      = '0;
      bad_count  = 0;
      pending_readings.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.step_delta     = out_mon.step_delta;
        got.position_count = out_mon.position_count;
        got.angle_deg      = out_mon.angle_deg;
        got.speed_rpm      = out_mon.speed_rpm;
        if (pending_readings.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t unexpected result transfer: delta %0d pos %0d angle %0d rpm %0d",
                     $realtime, got.step_delta, got.position_count, got.angle_deg,
                     got.speed_rpm);
        end else begin
          want = pending_readings.pop_front();
          if (got.step_delta !== want.step_delta ||
              got.position_count !== want.position_count ||
              got.angle_deg !== want.angle_deg ||
              got.speed_rpm !== want.speed_rpm) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t mismatch exp/got: delta %0d/%0d pos %0d/%0d angle %0d/%0d rpm %0d/%0d",
                       $realtime,
                       want.step_delta, got.step_delta,
                       want.position_count, got.position_count,
                       want.angle_deg, got.angle_deg,
                       want.speed_rpm, got.speed_rpm);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CPR:   cpr_q   = cfg_data[CPR_W-1:0];
          CFG_WIN:   win_q   = cfg_data[WIN_W-1:0];
          CFG_SCALE: scale_q = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        pending_readings.push_back(advance_encoder(kind_t'(in_mon.kind),
                                                   in_mon.counter_value,
                                                   in_mon.time_tick));
    end
    mismatches  <= bad_count;
    outstanding <= pending_readings.size();
  end

endmodule

@@ dv/tb_quadrature_position_speed_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadrature_position_speed_core
// Drives encoder samples, full and speed resets through the core under
// bursty sample timing and result stalls, over several register settings
// including the extremes, and leaves all checking to qps_result_check.
// ----------------------------------------------------------------------------
module tb_quadrature_position_speed_core;
  import qps_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  int                    cycle_count = 0;

  qps_in_if  in_ch ();
  qps_out_if out_ch ();

  quadrature_position_speed_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qps_result_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  logic [15:0] enc_cnt;
  logic [31:0] now_tick;
  int          win_now;
  int          burst_left;
  int          run_left;
  int          run_cls;
  int          run_step;
  int          stall_mode = 0;
  int          stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 2) ? $urandom_range(1, 80) : $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      2:       out_ch.ready <= 1'b0;
      default: out_ch.ready <= stall_left[0];
    endcase
  end

  task automatic send_item(input kind_t k, input logic [15:0] cnt, input logic [31:0] tick);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= k;
    in_ch.counter_value <= cnt;
    in_ch.time_tick     <= tick;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] cpr, input logic [15:0] win,
                           input logic [19:0] scale);
    quiesce();
    write_reg(CFG_CPR, CFG_DATA_W'(cpr));
    write_reg(CFG_WIN, CFG_DATA_W'(win));
    write_reg(CFG_SCALE, scale);
    win_now = int'(win);
  endtask

  task automatic advance_tick();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0)     now_tick = now_tick;
    else if (sel == 1) now_tick = $urandom;
    else if (sel < 5)  now_tick = now_tick + $urandom_range(win_now / 2, win_now * 2);
    else               now_tick = now_tick + $urandom_range(0, win_now / 8 + 1);
  endtask

  // encoder motion: runs of roughly constant speed with jitter
  task automatic advance_count();
    int mag;
    if (run_left == 0) begin
      run_cls  = $urandom_range(0, 4);
      run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                             : $urandom_range(5, 60);
      case (run_cls)
        0:       mag = $urandom_range(0, 20);
        1:       mag = $urandom_range(0, 3000);
        2:       mag = $urandom_range(16384, 32767);
        default: mag = 32767;
      endcase
      run_step = $urandom_range(0, 1) ? mag : -mag;
      if (run_cls == 3 && run_step < 0) run_step = -32768;
    end
    run_left--;
    if (run_cls == 4)      enc_cnt = 16'($urandom);
    else if (run_cls == 3) enc_cnt = enc_cnt + 16'(run_step);
    else                   enc_cnt = enc_cnt + 16'(run_step + $urandom_range(0, 6) - 3);
  endtask

  task automatic run_random(input int n);
    int sent;
    int sel;
    sent = 0;
    while (sent < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        send_item(KIND_NONE, 16'($urandom), $urandom);
      end else if (sel < 9) begin
        advance_tick();
        send_item(KIND_FULL_RST, 16'($urandom), now_tick);
        sent++;
      end else if (sel < 15) begin
        advance_tick();
        if ($urandom_range(0, 1)) enc_cnt = 16'($urandom);
        send_item(KIND_SPEED_RST, enc_cnt, now_tick);
        sent++;
      end else begin
        advance_tick();
        advance_count();
        send_item(KIND_UPDATE, enc_cnt, now_tick);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_UPDATE;
    in_ch.counter_value <= '0;
    in_ch.time_tick     <= '0;
    burst_left          = 0;
    run_left            = 0;
    run_cls             = 0;
    run_step            = 0;
    enc_cnt             = '0;
    now_tick            = '0;
    win_now             = int'(WIN_RST);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register reset values, wrap of the count delta, window edges, skip
    send_item(KIND_UPDATE,    16'h0000, 32'd0);
    send_item(KIND_UPDATE,    16'h7FFF, 32'd499);
    send_item(KIND_UPDATE,    16'hFFFF, 32'd500);
    send_item(KIND_UPDATE,    16'h7FFF, 32'd1000);
    send_item(KIND_NONE,      16'h1234, 32'hFFFF_FFFF);
    send_item(KIND_SPEED_RST, 16'h0100, 32'd2000);
    send_item(KIND_UPDATE,    16'h0200, 32'd2600);
    send_item(KIND_UPDATE,    16'h0300, 32'd3200);
    send_item(KIND_FULL_RST,  16'hFFFF, 32'hFFFF_FF00);
    send_item(KIND_UPDATE,    16'h8001, 32'h0000_00F3);
    send_item(KIND_UPDATE,    16'h8001, 32'h0000_00F4);
    send_item(KIND_SPEED_RST, 16'hFFFF, 32'h1234_5678);
    send_item(KIND_SPEED_RST, 16'h0000, 32'h1234_5678);
    send_item(KIND_UPDATE,    16'hAAAA, 32'hAAAA_AAAA);
    send_item(KIND_UPDATE,    16'h5555, 32'hFFFF_FFFF);
    send_item(KIND_NONE,      16'hFFFF, 32'h0000_0000);
    send_item(KIND_FULL_RST,  16'h0000, 32'h0000_0000);
    configure(16'd1, 16'd1, 20'd1_000_000);
    send_item(KIND_UPDATE,    16'h7FFF, 32'd1);
    send_item(KIND_UPDATE,    16'hFFFF, 32'd1);
    send_item(KIND_UPDATE,    16'h7FFF, 32'd2);
    configure(16'hFFFF, 16'hFFFF, 20'd1);
    send_item(KIND_UPDATE,    16'h8000, 32'd65537);
    send_item(KIND_UPDATE,    16'h0000, 32'd65538);

    configure(CPR_RST, WIN_RST, SCALE_RST);
    run_random(220);

    // long constant-speed run drives the angle past the 32-bit range
    configure(16'd1, 16'd1, 20'd1_000_000);
    run_cls  = 3;
    run_left = 220;
    run_step = $urandom_range(0, 1) ? 32767 : -32768;
    run_random(220);

    configure(16'hFFFF, 16'hFFFF, 20'd1);
    now_tick = 32'hFFFF_0000;
    run_random(220);

    configure(16'd360, 16'd100, 20'd60000);
    run_random(220);

    configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 20)),
              20'($urandom_range(1, 1_000_000)));
    run_random(220);

    configure(16'($urandom_range(1, 64)), 16'($urandom_range(1, 2000)),
              20'($urandom_range(1, 1_000_000)));
    run_random(220);

    quiesce();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
